/* rtl/core/pcdf_pkg.sv */
// Shared constants, command and status types of the piecewise CDF position lookup.
package pcdf_pkg;

  // Field widths and table geometry
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 24;

  // Shared divider geometry
  localparam int unsigned DIV_W      = KEY_W + FRAC_W;
  localparam int unsigned NUM_W      = IDX_W + FRAC_W;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned DIV1_STEPS = DIV_W;
  localparam int unsigned DIV2_STEPS = NUM_W;

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  // Table read address source
  typedef enum logic [2:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  // Result kind
  typedef enum logic [1:0] {
    EMIT_ZERO,
    EMIT_SAT,
    EMIT_INTERP
  } emit_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       search_upd;
    logic       d0_ld;
    logic       t_zero;
    logic       t_ld;
    logic       div1_start;
    logic       div2_start;
    logic       emit;
    emit_kind_e kind;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic in_write;
    logic few;
    logic key_le;
    logic key_ge;
    logic search_open;
    logic idx_zero;
    logic div_cond;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/pcdf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pcdf_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, dividend top-aligned.
module pcdf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pcdf_pkg::DIV_W-1:0]  dividend_i,
  input  logic [pcdf_pkg::KEY_W-1:0]  divisor_i,
  input  logic [pcdf_pkg::STEP_W-1:0] steps_i,
  output logic [pcdf_pkg::DIV_W-1:0]  quotient_o,
  output logic                        done_o
);
  import pcdf_pkg::*;

  logic [STEP_W-1:0] count_q, count_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [KEY_W-1:0]  rem_q, rem_d;
  logic [KEY_W-1:0]  dvs_q, dvs_d;
  logic [KEY_W:0]    trial;
  logic [KEY_W:0]    diff;
  logic              fits;

  // One restoring step
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // Load on start, shift while steps remain
  always_comb begin
    count_d = count_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      count_d = steps_i;
      quo_d   = dividend_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
    end else if (count_q != '0) begin
      count_d = count_q - STEP_W'(1);
      quo_d   = {quo_q[DIV_W-2:0], fits};
      rem_d   = fits ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = (count_q == '0);

endmodule

/* rtl/core/pcdf_datapath.sv */
// Datapath: count register, knot RAM, search bounds, divider and output register.
module pcdf_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcdf_pkg::cmd_t                  cmd_i,
  output pcdf_pkg::sts_t                  sts_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcdf_pkg::CNT_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [pcdf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [pcdf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import pcdf_pkg::*;

  logic [CNT_W-1:0]  knot_count_q;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  nm1;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  idx;
  logic [IDX_W-1:0]  left;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  d0_q;
  logic [FRAC_W-1:0] t_q;
  logic              in_acc;
  logic              ram_we;
  logic [IDX_W-1:0]  raddr;
  logic [KEY_W-1:0]  rdata;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [KEY_W-1:0]  div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic [DIV_W-1:0]  quot;
  logic              div_done;
  logic [FRAC_W-1:0] quot_sat;
  logic              out_valid_q;
  logic [FRAC_W-1:0] out_pos_q;
  logic [IDX_W-1:0]  out_seg_q;
  logic              out_free;

  // Configuration register, taken on every write transaction
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= '0;
    end else if (cfg_valid_i) begin
      knot_count_q <= cfg_data_i;
    end
  end

  // Clamp the count to the table size
  assign n_eff = (knot_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : knot_count_q;
  assign nm1   = n_eff - CNT_W'(1);

  // Input transaction
  assign s_axis_tready_o = cmd_i.accept;
  assign in_acc          = s_axis_tvalid_i && cmd_i.accept;
  assign ram_we          = in_acc && s_axis_tuser_i[0];

  // Search probe and segment indexes
  always_comb begin
    mid  = lo_q + ((hi_q - lo_q) >> 1);
    idx  = (lo_q > nm1) ? nm1 : lo_q;
    left = idx[IDX_W-1:0] - IDX_W'(1);
  end

  // Select the table read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: raddr = '0;
      RD_LAST:  raddr = nm1[IDX_W-1:0];
      RD_MID:   raddr = mid[IDX_W-1:0];
      RD_LEFT:  raddr = left;
      RD_RIGHT: raddr = idx[IDX_W-1:0];
      default:  raddr = '0;
    endcase
  end

  pcdf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_axis_tdata_i[IDX_W-1:0]),
    .wdata_i (s_axis_tdata_i[IDX_W+KEY_W-1:IDX_W]),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Search bounds: reset on accept, narrow after each probe
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (in_acc) begin
      lo_d = '0;
      hi_d = n_eff;
    end else if (cmd_i.search_upd) begin
      if (key_q >= rdata) begin
        lo_d = mid + CNT_W'(1);
      end else begin
        hi_d = mid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (in_acc) begin
      key_q <= s_axis_tdata_i[IDX_W+KEY_W-1:IDX_W];
    end
    if (cmd_i.d0_ld) begin
      d0_q <= rdata;
    end
    if (cmd_i.t_zero) begin
      t_q <= '0;
    end else if (cmd_i.t_ld) begin
      t_q <= quot_sat;
    end
  end

  // Shared divider: in-segment fraction first, then scale by count minus one
  assign div_start = cmd_i.div1_start || cmd_i.div2_start;

  always_comb begin
    if (cmd_i.div1_start) begin
      div_dividend = {key_q - d0_q, {FRAC_W{1'b0}}};
      div_divisor  = rdata - d0_q;
      div_steps    = STEP_W'(DIV1_STEPS);
    end else begin
      div_dividend = {left, t_q, {(DIV_W-NUM_W){1'b0}}};
      div_divisor  = {{(KEY_W-CNT_W){1'b0}}, nm1};
      div_steps    = STEP_W'(DIV2_STEPS);
    end
  end

  pcdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  assign quot_sat = (quot[DIV_W-1:FRAC_W] != '0) ? FRAC_MAX : quot[FRAC_W-1:0];

  // Output register: load on emit, drop when the transaction completes
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.kind)
        EMIT_SAT: begin
          out_pos_q <= FRAC_MAX;
          out_seg_q <= nm1[IDX_W-1:0] - IDX_W'(1);
        end
        EMIT_INTERP: begin
          out_pos_q <= quot_sat;
          out_seg_q <= left;
        end
        default: begin
          out_pos_q <= '0;
          out_seg_q <= '0;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-FRAC_W-IDX_W){1'b0}}, out_seg_q, out_pos_q};

  // Status to the controller
  always_comb begin
    sts_o             = '0;
    sts_o.in_valid    = s_axis_tvalid_i;
    sts_o.in_write    = s_axis_tuser_i[0];
    sts_o.few         = (n_eff < CNT_W'(2));
    sts_o.key_le      = (key_q <= rdata);
    sts_o.key_ge      = (key_q >= rdata);
    sts_o.search_open = (lo_q < hi_q);
    sts_o.idx_zero    = (lo_q == '0);
    sts_o.div_cond    = (rdata > d0_q) && (key_q > d0_q);
    sts_o.div_done    = div_done;
    sts_o.out_free    = out_free;
  end

endmodule

/* rtl/core/pcdf_ctrl.sv */
// Controller: sequences the clamp checks, the search probes and the two divisions.
module pcdf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcdf_pkg::sts_t sts_i,
  output pcdf_pkg::cmd_t cmd_o
);
  import pcdf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_PROBE,
    S_CMP,
    S_RD_RIGHT,
    S_LOAD_D1,
    S_DIV1,
    S_DIV2S,
    S_DIV2,
    S_EMIT
  } state_e;

  state_e     state_q, state_d;
  emit_kind_e kind_q, kind_d;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RD_FIRST;
    cmd_o.kind   = kind_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = 1'b1;
        if (sts_i.in_valid && !sts_i.in_write) begin
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        if (sts_i.few) begin
          kind_d  = EMIT_ZERO;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_FIRST;
          state_d      = S_CHK_FIRST;
        end
      end
      S_CHK_FIRST: begin
        if (sts_i.key_le) begin
          kind_d  = EMIT_ZERO;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (sts_i.key_ge) begin
          kind_d  = EMIT_SAT;
          state_d = S_EMIT;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.search_open) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MID;
          state_d      = S_CMP;
        end else if (sts_i.idx_zero) begin
          kind_d  = EMIT_ZERO;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d      = S_RD_RIGHT;
        end
      end
      S_CMP: begin
        cmd_o.search_upd = 1'b1;
        state_d          = S_PROBE;
      end
      S_RD_RIGHT: begin
        cmd_o.d0_ld  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_RIGHT;
        state_d      = S_LOAD_D1;
      end
      S_LOAD_D1: begin
        if (sts_i.div_cond) begin
          cmd_o.div1_start = 1'b1;
          state_d          = S_DIV1;
        end else begin
          cmd_o.t_zero = 1'b1;
          state_d      = S_DIV2S;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.t_ld = 1'b1;
          state_d    = S_DIV2S;
        end
      end
      S_DIV2S: begin
        cmd_o.div2_start = 1'b1;
        state_d          = S_DIV2;
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          kind_d  = EMIT_INTERP;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and result kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= EMIT_ZERO;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

/* rtl/core/piecewise_cdf_position_lookup.sv */
// Top level of the piecewise-linear CDF position lookup.
//
// Knot keys are written into a 32-entry table with transactions whose tuser bit is 1
// (taken while idle, no result); a transaction with tuser 0 queries a key and returns
// one result: the Q0.16 position and the left segment index. The user must set the knot
// count through the configuration channel only while the block is idle; the block itself
// does not enforce it. A query returns a zero position when the table holds fewer than
// two knots or the key clamps at the first knot, and a saturated one when it clamps at
// the last knot; for an interpolated key the single RAM read port serves the binary
// search, and one shared radix-2 divider runs 48 steps for the in-segment fraction and
// 21 steps for the division by count minus one. A finished result waits in the output
// register while the next transaction is accepted.
module piecewise_cdf_position_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: knot_count[5:0]
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcdf_pkg::CNT_W-1:0]      cfg_data_i,
  // Input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [pcdf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [4:0] knot_index, [36:5] key
  input  logic [0:0]                      s_axis_tuser_i,  // [0] mode
  // Result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [pcdf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // [15:0] position, [20:16] segment
);
  import pcdf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcdf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pcdf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

/* rtl/core/pcdf_chk.sv */
// Port-level assertions of the CDF position lookup and their bind.
module pcdf_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [0:0]                      s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pcdf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  // The input is ready again in the cycle after a table write
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0] |=> s_axis_tready_o)
    else $error("input not ready after a write transaction");

  // A query occupies the block after it is taken
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i[0] |=> !s_axis_tready_o)
    else $error("input ready right after a query transaction");

  // A zero position always comes with segment zero
  a_zero_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:0] == 16'd0) |-> (m_axis_tdata_o[20:16] == 5'd0))
    else $error("zero position with nonzero segment");

endmodule

bind piecewise_cdf_position_lookup pcdf_chk u_pcdf_chk (.*);
